@@ rtl/sha1de_pkg.sv @@
`timescale 1ns / 1ps

package sha1de_pkg;

  // block and chaining value types, word 0 in the lowest slice
  typedef logic [15:0][31:0] block_t;
  typedef logic [4:0][31:0]  chain_t;

  // initial chaining value, h0 in slice 0
  localparam chain_t SHA1_IV = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                32'hefcdab89, 32'h67452301};

  // round constants
  localparam logic [31:0] K_R0 = 32'h5a827999;
  localparam logic [31:0] K_R1 = 32'h6ed9eba1;
  localparam logic [31:0] K_R2 = 32'h8f1bbcdc;
  localparam logic [31:0] K_R3 = 32'hca62c1d6;

  // first padding byte
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // round count and counter width
  localparam int ROUNDS = 80;
  localparam int RND_W  = 7;

  // group boundaries of the round functions
  localparam logic [RND_W-1:0] RND_G1 = RND_W'(20);
  localparam logic [RND_W-1:0] RND_G2 = RND_W'(40);
  localparam logic [RND_W-1:0] RND_G3 = RND_W'(60);
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

  // last digest word position
  localparam logic [2:0] WORD_LAST = 3'd4;

  // compression unit sequencer
  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_FOLD
  } core_state_t;

  // message sequencer
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_GO_DATA,
    ST_WAIT_DATA,
    ST_PAD,
    ST_GO_P1,
    ST_WAIT_P1,
    ST_GO_LAST,
    ST_WAIT_LAST,
    ST_OUT
  } top_state_t;

  // control into the compression unit
  typedef struct packed {
    logic start;
    logic init;
  } core_ctl_t;

  // status from the compression unit
  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

  // round constant by round number
  function automatic logic [31:0] sha1_k(input logic [RND_W-1:0] t);
    logic [31:0] k;
    priority if (t < RND_G1) k = K_R0;
    else if (t < RND_G2)     k = K_R1;
    else if (t < RND_G3)     k = K_R2;
    else                     k = K_R3;
    return k;
  endfunction

  // round function by round number
  function automatic logic [31:0] sha1_f(input logic [RND_W-1:0] t,
                                         input logic [31:0] b,
                                         input logic [31:0] c,
                                         input logic [31:0] d);
    logic [31:0] f;
    priority if (t < RND_G1) f = (b & c) | (~b & d);
    else if (t < RND_G2)     f = b ^ c ^ d;
    else if (t < RND_G3)     f = (b & c) | (b & d) | (c & d);
    else                     f = b ^ c ^ d;
    return f;
  endfunction

endpackage

@@ rtl/sha1de_core.sv @@
`timescale 1ns / 1ps

module sha1de_core import sha1de_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  core_ctl_t ctl,
  input  block_t    block,
  output core_sts_t sts,
  output chain_t    chain
);

  core_state_t      state, state_next;
  logic [RND_W-1:0] rnd;
  logic [31:0]      a, b, c, d, e;
  block_t           w;
  logic [31:0]      tmp;
  logic [31:0]      w_new;

  // one round of the shared datapath
  always_comb begin
    tmp   = {a[26:0], a[31:27]} + sha1_f(rnd, b, c, d) + e + sha1_k(rnd) + w[0];
    w_new = w[13] ^ w[8] ^ w[2] ^ w[0];
    w_new = {w_new[30:0], w_new[31]};
  end

  // sequencer next state and status
  always_comb begin
    state_next = state;
    unique case (state)
      C_IDLE: begin
        if (ctl.start) state_next = C_ROUND;
      end
      C_ROUND: begin
        if (rnd == RND_LAST) state_next = C_FOLD;
      end
      C_FOLD: begin
        state_next = C_IDLE;
      end
      default: begin
        state_next = C_IDLE;
      end
    endcase
    sts.busy = (state != C_IDLE);
    sts.done = (state == C_FOLD);
  end

  // sequencer state and round counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      rnd   <= '0;
    end else begin
      state <= state_next;
      if (state == C_ROUND) rnd <= rnd + RND_W'(1);
      else                  rnd <= '0;
    end
  end

  // chaining words, folded in after the last round
  always_ff @(posedge clk) begin
    if (rst || ctl.init) begin
      chain <= SHA1_IV;
    end else if (state == C_FOLD) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
      chain[4] <= chain[4] + e;
    end
  end

  // working variables and schedule window
  always_ff @(posedge clk) begin
    if (state == C_IDLE && ctl.start) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
      e <= chain[4];
      w <= block;
    end else if (state == C_ROUND) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= tmp;
      w <= {w_new, w[15:1]};
    end
  end

  // round counter is cleared by every cycle outside the round phase
  assert property (@(posedge clk) disable iff (rst)
    (state != C_ROUND) |=> (rnd == '0))
    else $error("round counter not cleared");

  // fold comes right after the last round
  assert property (@(posedge clk) disable iff (rst)
    sts.done |-> ($past(state) == C_ROUND && $past(rnd) == RND_LAST))
    else $error("fold without the last round");

  // done is a single cycle pulse
  assert property (@(posedge clk) disable iff (rst)
    sts.done |=> !sts.done)
    else $error("done held longer than one cycle");

endmodule

@@ rtl/sha1_digest_engine_unit.sv @@
`timescale 1ns / 1ps

// SHA-1 digest engine.
// Input stream: one transaction per message byte. s_axis_tdata carries the byte,
// s_axis_tuser says whether the byte is present, s_axis_tlast ends the message.
// A transaction with tlast and no byte finishes the message (or hashes an empty one).
// Output stream: five transactions per message, digest word 0 (most significant)
// first; m_axis_tuser carries the word position, m_axis_tlast marks the fifth word.
// Input bytes are taken only while the engine is idle; every 64th byte starts a
// compression (start, rounds, fold) during which s_axis_tready is low. Its length
// is set by the single round unit doing one round per cycle.
// Finishing a message takes a pad step and one or two compressions before the
// first digest word shows; each word then waits for m_axis_tready and the engine
// holds everything while the receiver stalls.
// After the fifth word is taken the chaining words go back to the initial value
// and input is taken again on the next cycle. Reset (rst, synchronous) does the
// same and drops any partial message.

module sha1_digest_engine_unit import sha1de_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_axis_tuser,   // [0] has_byte
  input  logic        s_axis_tlast,   // final_req
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] digest_word
  output logic [2:0]  m_axis_tuser,   // [2:0] word_index
  output logic        m_axis_tlast    // last_word
);

  top_state_t  state, state_next;
  logic [60:0] byte_cnt;
  logic [5:0]  pos;
  logic [3:0]  lim;
  logic        two_blk;
  logic        fin_pend;
  logic [2:0]  out_idx;
  logic [31:0] bufw [16];
  logic        in_acc, out_acc;
  logic        wr_en;
  logic [7:0]  wr_byte;
  logic [63:0] bit_len;
  logic        full, zero_all, use_len;
  block_t      view;
  core_ctl_t   core_ctl;
  core_sts_t   core_sts;
  chain_t      chain;

  assign pos     = byte_cnt[5:0];
  assign bit_len = {byte_cnt, 3'b000};
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // block presented to the compression unit
  always_comb begin
    full     = (state == ST_GO_DATA);
    use_len  = (state == ST_GO_LAST);
    zero_all = use_len && two_blk;
    for (int i = 0; i < 16; i++) begin
      if (full || (!zero_all && (4'(i) <= lim))) view[i] = bufw[i];
      else                                       view[i] = '0;
    end
    if (use_len) begin
      view[14] = bit_len[63:32];
      view[15] = bit_len[31:0];
    end
  end

  // message sequencer next state and handshakes
  always_comb begin
    state_next     = state;
    s_axis_tready  = (state == ST_IDLE);
    m_axis_tvalid  = (state == ST_OUT);
    core_ctl.start = (state == ST_GO_DATA) || (state == ST_GO_P1) ||
                     (state == ST_GO_LAST);
    core_ctl.init  = out_acc && (out_idx == WORD_LAST);
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser[0] && pos == 6'd63) state_next = ST_GO_DATA;
          else if (s_axis_tlast)              state_next = ST_PAD;
        end
      end
      ST_GO_DATA: state_next = ST_WAIT_DATA;
      ST_WAIT_DATA: begin
        if (core_sts.done) state_next = fin_pend ? ST_PAD : ST_IDLE;
      end
      ST_PAD: state_next = (pos >= 6'd56) ? ST_GO_P1 : ST_GO_LAST;
      ST_GO_P1: state_next = ST_WAIT_P1;
      ST_WAIT_P1: begin
        if (core_sts.done) state_next = ST_GO_LAST;
      end
      ST_GO_LAST: state_next = ST_WAIT_LAST;
      ST_WAIT_LAST: begin
        if (core_sts.done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_acc && out_idx == WORD_LAST) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer state, byte count and output position
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      byte_cnt <= '0;
      fin_pend <= 1'b0;
      out_idx  <= '0;
    end else begin
      state <= state_next;
      if (in_acc) begin
        fin_pend <= s_axis_tlast;
        if (s_axis_tuser[0]) byte_cnt <= byte_cnt + 61'd1;
      end
      if (out_acc) begin
        if (out_idx == WORD_LAST) begin
          out_idx  <= '0;
          byte_cnt <= '0;
        end else begin
          out_idx <= out_idx + 3'd1;
        end
      end
    end
  end

  // pad bookkeeping
  always_ff @(posedge clk) begin
    if (state == ST_PAD) begin
      two_blk <= (pos >= 6'd56);
      lim     <= pos[5:2];
    end
  end

  // byte packing, a byte in lane 0 clears the rest of its word
  assign wr_en   = (in_acc && s_axis_tuser[0]) || (state == ST_PAD);
  assign wr_byte = (state == ST_PAD) ? PAD_BYTE : s_axis_tdata;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      unique case (pos[1:0])
        2'd0: bufw[pos[5:2]]        <= {wr_byte, 24'h000000};
        2'd1: bufw[pos[5:2]][23:16] <= wr_byte;
        2'd2: bufw[pos[5:2]][15:8]  <= wr_byte;
        2'd3: bufw[pos[5:2]][7:0]   <= wr_byte;
        default: ;
      endcase
    end
  end

  // shared round unit with chaining words
  sha1de_core u_core (
    .clk   (clk),
    .rst   (rst),
    .ctl   (core_ctl),
    .block (view),
    .sts   (core_sts),
    .chain (chain)
  );

  // digest words straight from the chaining registers
  assign m_axis_tdata = chain[out_idx];
  assign m_axis_tuser = out_idx;
  assign m_axis_tlast = (out_idx == WORD_LAST);

  // input and output never open at once
  assert property (@(posedge clk) disable iff (rst)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input and output open together");

  // a compression is launched only on an idle unit
  assert property (@(posedge clk) disable iff (rst)
    core_ctl.start |-> !core_sts.busy)
    else $error("compression started while busy");

  // a digest word position never passes the last word
  assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (out_idx <= WORD_LAST))
    else $error("digest word position out of range");

endmodule
